// ===== rtl/dersig_pkg.sv =====
// Shared beat types and DER constants for the DER ECDSA signature parser.
package dersig_pkg;

   localparam logic [7:0] TAG_SEQUENCE = 8'h30;
   localparam logic [7:0] TAG_INTEGER  = 8'h02;
   localparam logic [7:0] LEN_LONG     = 8'h80;
   localparam logic [7:0] LEN_MASK     = 8'h7F;
   localparam int         CNT_W        = 13;
   localparam int         ACC_W        = 32;

   typedef struct packed {
      logic [7:0] sig_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             byte_valid;
      logic             part;
      logic             done_res;
      logic             ok;
      logic [CNT_W-1:0] r_length;
      logic [CNT_W-1:0] s_length;
   } rsp_type;

endpackage

// ===== rtl/dersig_core.sv =====
// Parse state registers and per-byte next-state logic of the DER signature parser.
module dersig_core #(
   parameter int MAX_SIG_BYTES = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  dersig_pkg::req_type item,
   output logic              emit,
   output dersig_pkg::rsp_type result
);
   import dersig_pkg::*;

   localparam int OUT_W = $clog2(MAX_SIG_BYTES + 1);
   localparam logic [ACC_W-1:0] MAX_LEN = ACC_W'(MAX_SIG_BYTES);

   localparam logic [3:0] PH_OTAG  = 4'd0;
   localparam logic [3:0] PH_OLEN  = 4'd1;
   localparam logic [3:0] PH_OLENX = 4'd2;
   localparam logic [3:0] PH_RTAG  = 4'd3;
   localparam logic [3:0] PH_RLEN  = 4'd4;
   localparam logic [3:0] PH_RLENX = 4'd5;
   localparam logic [3:0] PH_RDATA = 4'd6;
   localparam logic [3:0] PH_STAG  = 4'd7;
   localparam logic [3:0] PH_SLEN  = 4'd8;
   localparam logic [3:0] PH_SLENX = 4'd9;
   localparam logic [3:0] PH_SDATA = 4'd10;
   localparam logic [3:0] PH_TRAIL = 4'd11;

   logic [3:0]       phase_ff, phase_in;
   logic [2:0]       lbl_ff, lbl_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [OUT_W-1:0] outer_ff, outer_in;
   logic [OUT_W-1:0] field_ff, field_in;
   logic             strip_ff, strip_in;
   logic             err_ff, err_in;
   logic [CNT_W-1:0] rcnt_ff, rcnt_in;
   logic [CNT_W-1:0] scnt_ff, scnt_in;

   logic [7:0]       b;
   logic [ACC_W-1:0] acc_next;
   logic [2:0]       lbl_dec;
   logic [6:0]       n_len;
   logic             finish;
   logic [ACC_W-1:0] len_sel;
   logic             len_nz;
   logic             valid;
   logic             part;
   logic             good;

   always_comb begin
      b        = item.sig_byte;
      acc_next = {acc_ff[ACC_W-9:0], b};
      lbl_dec  = lbl_ff - 3'd1;
      n_len    = b[6:0] & LEN_MASK[6:0];
      len_nz   = 1'b0;
      phase_in = phase_ff;
      lbl_in   = lbl_ff;
      acc_in   = acc_ff;
      outer_in = outer_ff;
      field_in = field_ff;
      strip_in = strip_ff;
      err_in   = err_ff;
      rcnt_in  = rcnt_ff;
      scnt_in  = scnt_ff;
      valid    = 1'b0;
      part     = 1'b0;
      finish   = 1'b0;
      len_sel  = '0;
      good     = 1'b0;

      if (!err_ff && phase_ff >= PH_RTAG) begin
         if (outer_ff == '0) err_in = 1'b1;
         else outer_in = outer_ff - OUT_W'(1);
      end

      if (!err_in) begin
         case (phase_ff)
            PH_OTAG: begin
               if (b != TAG_SEQUENCE) err_in = 1'b1;
               else phase_in = PH_OLEN;
            end
            PH_RTAG: begin
               if (b != TAG_INTEGER) err_in = 1'b1;
               else phase_in = PH_RLEN;
            end
            PH_STAG: begin
               if (b != TAG_INTEGER) err_in = 1'b1;
               else phase_in = PH_SLEN;
            end
            PH_OLEN, PH_RLEN, PH_SLEN: begin
               if ((b & LEN_LONG) == 8'h00) begin
                  finish  = 1'b1;
                  len_sel = ACC_W'(b);
               end else if (n_len < 7'd1 || n_len > 7'd4) begin
                  err_in = 1'b1;
               end else begin
                  lbl_in   = n_len[2:0];
                  acc_in   = '0;
                  phase_in = phase_ff + 4'd1;
               end
            end
            PH_OLENX, PH_RLENX, PH_SLENX: begin
               acc_in  = acc_next;
               lbl_in  = lbl_dec;
               len_sel = acc_next;
               finish  = (lbl_dec == 3'd0);
            end
            PH_RDATA, PH_SDATA: begin
               if (!(strip_ff && b == 8'h00)) begin
                  strip_in = 1'b0;
                  valid    = 1'b1;
                  if (phase_ff == PH_RDATA) rcnt_in = rcnt_ff + CNT_W'(1);
                  else begin
                     part    = 1'b1;
                     scnt_in = scnt_ff + CNT_W'(1);
                  end
               end
               field_in = field_ff - OUT_W'(1);
               if (field_in == '0) phase_in = (phase_ff == PH_RDATA) ? PH_STAG : PH_TRAIL;
            end
            default: begin
            end
         endcase

         if (finish) begin
            len_nz = (len_sel != '0);
            if (phase_ff inside {PH_OLEN, PH_OLENX}) begin
               if (len_sel > MAX_LEN) err_in = 1'b1;
               else begin
                  outer_in = len_sel[OUT_W-1:0];
                  phase_in = PH_RTAG;
               end
            end else if (len_sel > ACC_W'(outer_in)) begin
               err_in = 1'b1;
            end else begin
               field_in = len_sel[OUT_W-1:0];
               strip_in = 1'b1;
               if (phase_ff inside {PH_RLEN, PH_RLENX}) phase_in = len_nz ? PH_RDATA : PH_STAG;
               else phase_in = len_nz ? PH_SDATA : PH_TRAIL;
            end
         end
      end

      good = item.final_byte && !err_in && phase_in == PH_TRAIL && outer_in == '0;

      emit              = valid || item.final_byte;
      result.out_byte   = valid ? b : 8'h00;
      result.byte_valid = valid;
      result.part       = valid ? part : 1'b0;
      result.done_res   = item.final_byte;
      result.ok         = good;
      result.r_length   = good ? rcnt_in : '0;
      result.s_length   = good ? scnt_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OTAG;
         lbl_ff   <= '0;
         acc_ff   <= '0;
         outer_ff <= '0;
         field_ff <= '0;
         strip_ff <= 1'b1;
         err_ff   <= 1'b0;
         rcnt_ff  <= '0;
         scnt_ff  <= '0;
      end else if (step) begin
         if (item.final_byte) begin
            phase_ff <= PH_OTAG;
            lbl_ff   <= '0;
            acc_ff   <= '0;
            outer_ff <= '0;
            field_ff <= '0;
            strip_ff <= 1'b1;
            err_ff   <= 1'b0;
            rcnt_ff  <= '0;
            scnt_ff  <= '0;
         end else begin
            phase_ff <= phase_in;
            lbl_ff   <= lbl_in;
            acc_ff   <= acc_in;
            outer_ff <= outer_in;
            field_ff <= field_in;
            strip_ff <= strip_in;
            err_ff   <= err_in;
            rcnt_ff  <= rcnt_in;
            scnt_ff  <= scnt_in;
         end
      end
   end

endmodule

// ===== rtl/der_ecdsa_signature_parser.sv =====
// Top level of the DER ECDSA signature parser: input register, parser core, result register.
//
// Usage: feed the DER signature one byte per beat on req_data, with final_byte set on
// its last byte. A beat moves when req_valid is high and req_stall is low.
// Each r or s content byte left after dropping leading zeros comes out as one rsp beat
// with byte_valid set and part telling r (0) from s (1). The final byte always yields a
// beat with done_res set; ok, r_length and s_length report the status there. Bytes that
// carry neither produce no rsp beat.
// Path: the input register feeds the parse step, whose outcome lands in the result
// register that drives rsp_valid and rsp_data.
// Throughput: one byte per cycle while rsp_stall is low, set by the single parse step.
// Stall: while a result waits under rsp_stall, one more input beat is still taken into the
// input register; req_stall then rises until the result register frees.
// Reset: clears both valid flags and returns the parser to expect the outer SEQUENCE tag;
// the parser also returns there by itself after every final byte.
module der_ecdsa_signature_parser #(
   parameter int MAX_SIG_BYTES = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  dersig_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output dersig_pkg::rsp_type rsp_data
);
   import dersig_pkg::*;

   logic    in_vld_ff, in_vld_in;
   req_type in_data_ff;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_data_ff;
   logic    out_free;
   logic    accept;
   logic    step;
   logic    emit;
   rsp_type result;

   dersig_core #(
      .MAX_SIG_BYTES(MAX_SIG_BYTES)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (in_data_ff),
      .emit  (emit),
      .result(result)
   );

   always_comb begin
      out_free  = !out_vld_ff || !rsp_stall;
      step      = in_vld_ff && out_free;
      req_stall = in_vld_ff && !out_free;
      accept    = req_valid && !req_stall;
      if (accept) in_vld_in = 1'b1;
      else if (step) in_vld_in = 1'b0;
      else in_vld_in = in_vld_ff;
      if (step && emit) out_vld_in = 1'b1;
      else if (!rsp_stall) out_vld_in = 1'b0;
      else out_vld_in = out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) in_data_ff <= req_data;
      if (step && emit) out_data_ff <= result;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

   a_rsp_has_content: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.byte_valid || rsp_data.done_res))
      else $error("result beat carries neither a content byte nor a status");

   a_status_only_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.done_res) |->
         (!rsp_data.ok && rsp_data.r_length == '0 && rsp_data.s_length == '0))
      else $error("status fields set on a non-final result beat");

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_vld_ff && out_vld_ff && rsp_stall))
      else $error("input stalled while the pipeline can advance");

   a_step_fills_output: assert property (@(posedge clock) disable iff (reset)
      (step && emit) |=> rsp_valid)
      else $error("result of a processed byte was lost");

endmodule
